/* sv/dmsh_pkg.sv */
package dmsh_pkg;

  localparam int unsigned HashAW = 27;
  localparam int unsigned HashBW = 30;
  localparam int unsigned PosW   = 13;
  localparam int unsigned CharW  = 8;

  localparam logic [HashAW-1:0] ModA    = 27'd127657753;
  localparam logic [HashBW-1:0] ModB    = 30'd987654319;
  localparam logic [HashAW-1:0] BaseA   = 27'd137;
  localparam logic [HashBW-1:0] BaseB   = 30'd277;
  // Modular inverses of the bases (Fermat: base^(p-2) mod p).
  localparam logic [HashAW-1:0] InvBaseA = 27'd11181701;
  localparam logic [HashBW-1:0] InvBaseB = 30'd802246288;

  // Barrett constants: floor(2^(2k) / p) for a k-bit modulus p.
  localparam logic [HashAW:0] MuA = (HashAW+1)'((64'd1 << (2*HashAW)) / 64'(ModA));
  localparam logic [HashBW:0] MuB = (HashBW+1)'((64'd1 << (2*HashBW)) / 64'(ModB));

  typedef enum logic [1:0] {
    CmdAppend = 2'd0,
    CmdQuery  = 2'd1,
    CmdClear  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StSub,
    StMul,
    StQuo,
    StEst,
    StDif,
    StFix,
    StAcc,
    StOut
  } state_e;

  // Multiply-reduce passes of an append.
  typedef enum logic [1:0] {
    PassPrefix,
    PassPower,
    PassInverse
  } pass_e;

  typedef struct packed {
    logic [HashAW-1:0] a;
    logic [HashBW-1:0] b;
  } hpair_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [CharW-1:0]  char_code;
    logic [PosW-1:0]   left;
    logic [PosW-1:0]   right;
  } req_t;

  typedef struct packed {
    logic [HashAW-1:0] hash_a;
    logic [HashBW-1:0] hash_b;
    logic              error;
  } rsp_t;

endpackage

/* sv/dmsh_if.sv */
interface dmsh_req_if;
  import dmsh_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dmsh_rsp_if;
  import dmsh_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/double_mod_substring_hash.sv */
// Sequential: a word is accepted only after the previous result has left.
// A clear or an error word goes from the read state straight to the output state; a
// query runs one multiply-reduce pass and an append three (prefix, power, inverse),
// each through the multiply, quotient, estimate, difference, fix and accumulate states.
// Reset (rst_ni low, asynchronous) empties the string; the tables are not
// cleared, as no entry is read before it has been written.
module double_mod_substring_hash #(
  parameter int unsigned MAX_LEN = 4096
) (
  input logic clk_i,
  input logic rst_ni,
  dmsh_req_if.sink   req,
  dmsh_rsp_if.source rsp
);
  import dmsh_pkg::*;

  localparam int unsigned AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LenW  = $clog2(MAX_LEN + 1);
  // A Barrett remainder lies below 3p, which needs two bits above the modulus.
  localparam int unsigned DifAW = HashAW + 2;
  localparam int unsigned DifBW = HashBW + 2;

  state_e st_q, st_d;
  req_t   r_q;
  logic [LenW-1:0] len_q;
  hpair_t last_q, pow_q, inv_q;
  pass_e  pass_q;
  hpair_t newp_q;

  // Tables: prefix hashes and inverse powers, one 57-bit entry each.
  hpair_t pre_mem [MAX_LEN];
  hpair_t ipw_mem [MAX_LEN];
  hpair_t hi_q, lo_q, ip_q;
  logic   lo_zero_q;

  logic [AddrW-1:0] hi_addr, lo_addr, ip_addr, wr_addr;
  logic             wr_en;

  // Datapath registers: operands, products, quotient estimates and remainders.
  logic [HashAW-1:0] opa_x_q, opa_y_q;
  logic [HashBW-1:0] opb_x_q, opb_y_q;
  logic [HashAW-1:0] adda_q;
  logic [HashBW-1:0] addb_q;
  logic [2*HashAW-1:0] pa_q;
  logic [2*HashBW-1:0] pb_q;
  logic [HashAW:0]   qa_q;
  logic [HashBW:0]   qb_q;
  logic [DifAW-1:0]  qma_q, difa_q;
  logic [DifBW-1:0]  qmb_q, difb_q;
  logic [HashAW-1:0] fixa_q;
  logic [HashBW-1:0] fixb_q;
  logic [HashAW-1:0] resa_q;
  logic [HashBW-1:0] resb_q;
  logic              err_q;

  logic accept;
  logic range_ok;
  logic room_ok;
  logic is_append;

  assign accept  = req.valid && req.ready;
  assign req.ready = (st_q == StIdle);
  assign rsp.valid = (st_q == StOut);
  assign rsp.data  = '{hash_a: resa_q, hash_b: resb_q, error: err_q};

  assign is_append = (r_q.command == CmdAppend);
  assign room_ok   = (len_q < LenW'(MAX_LEN));
  assign range_ok  = (r_q.left != '0) && (r_q.right >= r_q.left) &&
                     (32'(r_q.right) <= 32'(len_q));

  assign hi_addr = AddrW'(r_q.right - PosW'(1));
  assign lo_addr = AddrW'(r_q.left - PosW'(2));
  assign ip_addr = AddrW'(r_q.left - PosW'(1));
  assign wr_addr = AddrW'(len_q);

  // The new prefix and the old inverse power are stored once all passes are done.
  assign wr_en = (st_q == StAcc) && is_append && (pass_q == PassInverse);

  // Memory ports; reads registered.
  always_ff @(posedge clk_i) begin
    if (st_q == StRead && r_q.command == CmdQuery) begin
      hi_q <= pre_mem[hi_addr];
      lo_q <= pre_mem[lo_addr];
      ip_q <= ipw_mem[ip_addr];
    end
    if (wr_en) begin
      pre_mem[wr_addr] <= newp_q;
      ipw_mem[wr_addr] <= inv_q;
    end
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (accept) st_d = StRead;
      StRead: begin
        if ((is_append && room_ok) || (r_q.command == CmdQuery && range_ok)) st_d = StSub;
        else st_d = StOut;
      end
      StSub:  st_d = StMul;
      StMul:  st_d = StQuo;
      StQuo:  st_d = StEst;
      StEst:  st_d = StDif;
      StDif:  st_d = StFix;
      StFix:  st_d = StAcc;
      StAcc: begin
        if (is_append && pass_q != PassInverse) st_d = StMul;
        else st_d = StOut;
      end
      StOut:  if (rsp.ready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end

  // Lower prefix of a query, zero when the range starts at the first character.
  logic [HashAW-1:0] lo_a;
  logic [HashBW-1:0] lo_b;
  assign lo_a = lo_zero_q ? '0 : lo_q.a;
  assign lo_b = lo_zero_q ? '0 : lo_q.b;

  // Barrett quotient estimate: the top bits of the product times the reciprocal.
  logic [2*HashAW+1:0] qpa;
  logic [2*HashBW+1:0] qpb;
  assign qpa = (2*HashAW+2)'(pa_q[2*HashAW-1:HashAW-1]) * (2*HashAW+2)'(MuA);
  assign qpb = (2*HashBW+2)'(pb_q[2*HashBW-1:HashBW-1]) * (2*HashBW+2)'(MuB);

  // The remainder estimate is below 3p; at most two subtractions of p remain.
  logic [HashAW-1:0] fixa;
  logic [HashBW-1:0] fixb;
  assign fixa = (difa_q >= {1'b0, ModA, 1'b0}) ? HashAW'(difa_q - {1'b0, ModA, 1'b0}) :
                (difa_q >= {2'b00, ModA}) ? HashAW'(difa_q - {2'b00, ModA}) :
                HashAW'(difa_q);
  assign fixb = (difb_q >= {1'b0, ModB, 1'b0}) ? HashBW'(difb_q - {1'b0, ModB, 1'b0}) :
                (difb_q >= {2'b00, ModB}) ? HashBW'(difb_q - {2'b00, ModB}) :
                HashBW'(difb_q);

  // Accumulator term added to the reduced product, folded once.
  logic [HashAW:0] suma;
  logic [HashBW:0] sumb;
  logic [HashAW-1:0] acca;
  logic [HashBW-1:0] accb;
  assign suma = {1'b0, adda_q} + {1'b0, fixa_q};
  assign sumb = {1'b0, addb_q} + {1'b0, fixb_q};
  assign acca = (suma >= {1'b0, ModA}) ? HashAW'(suma - {1'b0, ModA}) : HashAW'(suma);
  assign accb = (sumb >= {1'b0, ModB}) ? HashBW'(sumb - {1'b0, ModB}) : HashBW'(sumb);

  // Control and datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q       <= '0;
      len_q     <= '0;
      last_q    <= '0;
      pow_q     <= '{a: HashAW'(1), b: HashBW'(1)};
      inv_q     <= '{a: HashAW'(1), b: HashBW'(1)};
      newp_q    <= '0;
      pass_q    <= PassPrefix;
      err_q     <= 1'b0;
      lo_zero_q <= 1'b0;
      opa_x_q   <= '0;
      opa_y_q   <= '0;
      opb_x_q   <= '0;
      opb_y_q   <= '0;
      adda_q    <= '0;
      addb_q    <= '0;
      pa_q      <= '0;
      pb_q      <= '0;
      qa_q      <= '0;
      qb_q      <= '0;
      qma_q     <= '0;
      qmb_q     <= '0;
      difa_q    <= '0;
      difb_q    <= '0;
      fixa_q    <= '0;
      fixb_q    <= '0;
      resa_q    <= '0;
      resb_q    <= '0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (accept) r_q <= req.data;
          pass_q <= PassPrefix;
        end
        StRead: begin
          resa_q <= '0;
          resb_q <= '0;
          lo_zero_q <= (r_q.left < PosW'(2));
          priority if (is_append) begin
            err_q <= !room_ok;
          end else if (r_q.command == CmdQuery) begin
            err_q <= !range_ok;
          end else if (r_q.command == CmdClear) begin
            err_q  <= 1'b0;
            len_q  <= '0;
            last_q <= '0;
            pow_q  <= '{a: HashAW'(1), b: HashBW'(1)};
            inv_q  <= '{a: HashAW'(1), b: HashBW'(1)};
          end else begin
            err_q <= 1'b1;
          end
        end
        StSub: begin
          if (is_append) begin
            opa_x_q <= pow_q.a;
            opb_x_q <= pow_q.b;
            opa_y_q <= HashAW'(r_q.char_code);
            opb_y_q <= HashBW'(r_q.char_code);
            adda_q  <= last_q.a;
            addb_q  <= last_q.b;
          end else begin
            // (hi - lo) mod p, each half below p.
            opa_x_q <= (hi_q.a >= lo_a) ? hi_q.a - lo_a : hi_q.a + (ModA - lo_a);
            opb_x_q <= (hi_q.b >= lo_b) ? hi_q.b - lo_b : hi_q.b + (ModB - lo_b);
            opa_y_q <= ip_q.a;
            opb_y_q <= ip_q.b;
            adda_q  <= '0;
            addb_q  <= '0;
          end
        end
        StMul: begin
          pa_q <= (2*HashAW)'(opa_x_q) * (2*HashAW)'(opa_y_q);
          pb_q <= (2*HashBW)'(opb_x_q) * (2*HashBW)'(opb_y_q);
        end
        StQuo: begin
          qa_q <= qpa[2*HashAW+1:HashAW+1];
          qb_q <= qpb[2*HashBW+1:HashBW+1];
        end
        StEst: begin
          // Only the low bits matter: the true remainder fits in them.
          qma_q <= DifAW'(qa_q) * DifAW'(ModA);
          qmb_q <= DifBW'(qb_q) * DifBW'(ModB);
        end
        StDif: begin
          difa_q <= pa_q[DifAW-1:0] - qma_q;
          difb_q <= pb_q[DifBW-1:0] - qmb_q;
        end
        StFix: begin
          fixa_q <= fixa;
          fixb_q <= fixb;
        end
        StAcc: begin
          if (is_append) begin
            unique case (pass_q)
              PassPrefix: begin
                newp_q  <= '{a: acca, b: accb};
                opa_x_q <= pow_q.a;  opa_y_q <= BaseA;
                opb_x_q <= pow_q.b;  opb_y_q <= BaseB;
                adda_q  <= '0;       addb_q  <= '0;
                pass_q  <= PassPower;
              end
              PassPower: begin
                pow_q   <= '{a: acca, b: accb};
                opa_x_q <= inv_q.a;  opa_y_q <= InvBaseA;
                opb_x_q <= inv_q.b;  opb_y_q <= InvBaseB;
                pass_q  <= PassInverse;
              end
              // Last pass: commit the new character and present its prefix.
              default: begin
                inv_q  <= '{a: acca, b: accb};
                last_q <= newp_q;
                len_q  <= len_q + LenW'(1);
                resa_q <= newp_q.a;
                resb_q <= newp_q.b;
                pass_q <= PassPrefix;
              end
            endcase
          end else begin
            resa_q <= acca;
            resb_q <= accb;
          end
        end
        StOut: ;
        default: ;
      endcase
    end
  end

endmodule

/* sv/dmsh_checker.sv */
module dmsh_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_error,
  input logic [29:0] rsp_hash_b,
  input logic [26:0] rsp_hash_a
);
  // One word in flight: no new acceptance while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("accepted while result pending");
  // An error result carries zero hashes.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && rsp_error) |-> (rsp_hash_a == '0 && rsp_hash_b == '0))
    else $error("error with nonzero hash");
  // Hashes stay below their moduli.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_hash_a < 27'd127657753 && rsp_hash_b < 30'd987654319))
    else $error("hash out of range");
  // A held result stays valid and its hash_a stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hash_a)))
    else $error("result dropped");
endmodule

bind double_mod_substring_hash dmsh_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_error(rsp.data.error), .rsp_hash_b(rsp.data.hash_b),
  .rsp_hash_a(rsp.data.hash_a)
);
